// ===== src/sacam_pkg.sv =====
// sacam_pkg: shared types and constants for the set-associative cache access model
// holds the way entry layout, register index codes and the sequencer state type
// no dependencies
`timescale 1ns / 1ps

package sacam_pkg;

    localparam int MAX_SETS_DEF  = 256;
    localparam int NUM_WAYS_DEF  = 4;

    localparam int TAG_W         = 30;
    localparam int STAMP_W       = 64;
    localparam int COST_W        = 16;
    localparam int CNT_W         = 32;
    localparam int ADDR_W        = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;
    localparam int M_DATA_W      = 280;

    localparam logic [COST_W-1:0] MEM_CYCLES = 16'd100;
    localparam logic [3:0] OFF_MIN = 4'd2;
    localparam logic [3:0] OFF_MAX = 4'd10;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_BACK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOC = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE     = 3'd5;

    typedef struct packed {
        logic               valid;
        logic               dirty;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] fill_stamp;
        logic [STAMP_W-1:0] use_stamp;
    } way_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE
    } state_t;

endpackage

// ===== src/sacam_set_store.sv =====
// sacam_set_store: set memory, one row holds every way of one set
// registered read port and one write port; per-row init bits hide stale rows after reset
// depends on sacam_pkg
`timescale 1ns / 1ps

module sacam_set_store #(
    parameter int NUM_WAYS = sacam_pkg::NUM_WAYS_DEF,
    parameter int ROWS     = 1,
    parameter int SET_W    = 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  rd_en,
    input  logic [SET_W-1:0]                      rd_addr,
    output sacam_pkg::way_entry_t [NUM_WAYS-1:0]  rd_row,
    input  logic                                  wr_en,
    input  logic [SET_W-1:0]                      wr_addr,
    input  sacam_pkg::way_entry_t [NUM_WAYS-1:0]  wr_row
);

    sacam_pkg::way_entry_t [NUM_WAYS-1:0] mem [ROWS];
    logic [ROWS-1:0]                      row_init_reg;
    sacam_pkg::way_entry_t [NUM_WAYS-1:0] rd_data_reg;
    logic                                 rd_init_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_init_reg <= '0;
            rd_init_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_init_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_init_reg <= row_init_reg[rd_addr] && !(wr_en && wr_addr == rd_addr);
            end
        end
    end

    // a row never written reads as all ways invalid and clean
    always_comb begin
        rd_row = rd_data_reg;
        for (int i = 0; i < NUM_WAYS; i++) begin
            rd_row[i].valid = rd_data_reg[i].valid & rd_init_reg;
            rd_row[i].dirty = rd_data_reg[i].dirty & rd_init_reg;
        end
    end

endmodule

// ===== src/set_assoc_cache_access_model.sv =====
// set_assoc_cache_access_model: top level, sequencer, way scan, counters and stream ports
// depends on sacam_pkg and sacam_set_store
//
// One load or store word is taken at a time. The access reads its set from memory,
// scans the ways in use one per cycle through a single tag and stamp comparator,
// then writes the updated set and posts the result. The result sits in an output
// register, so the next access may start while it waits; the update of that next
// access waits for it to be taken. No clearing pass is needed after reset.
// Configuration writes are always taken.
`timescale 1ns / 1ps

module set_assoc_cache_access_model #(
    parameter int MAX_SETS = sacam_pkg::MAX_SETS_DEF,
    parameter int NUM_WAYS = sacam_pkg::NUM_WAYS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sacam_pkg::ADDR_W-1:0]        s_tdata,   // address
    input  logic [0:0]                          s_tuser,   // command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit, wrote_back, filled, cycle_cost, load_hit_count, load_miss_count,
    // store_hit_count, store_miss_count, load_total, store_total, cycle_total, zero pad
    output logic [sacam_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sacam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sacam_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int ROWS   = 1 << IB_MAX;
    localparam int SET_W  = (IB_MAX > 0) ? IB_MAX : 1;
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int WC_W   = $clog2(NUM_WAYS + 1);
    localparam int TAG_W  = sacam_pkg::TAG_W;
    localparam int ST_W   = sacam_pkg::STAMP_W;
    localparam int CST_W  = sacam_pkg::COST_W;
    localparam int CNT_W  = sacam_pkg::CNT_W;

    // configuration
    logic [3:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [2:0] ways_reg;
    logic       write_back_reg;
    logic       write_alloc_reg;
    logic       replace_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= 4'd4;
            index_bits_reg  <= 4'd0;
            ways_reg        <= 3'd1;
            write_back_reg  <= 1'b1;
            write_alloc_reg <= 1'b1;
            replace_reg     <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sacam_pkg::REG_OFFSET_BITS: offset_bits_reg <= cfg_data[3:0];
                sacam_pkg::REG_INDEX_BITS:  index_bits_reg  <= cfg_data[3:0];
                sacam_pkg::REG_WAYS:        ways_reg        <= cfg_data[2:0];
                sacam_pkg::REG_WRITE_BACK:  write_back_reg  <= cfg_data[0];
                sacam_pkg::REG_WRITE_ALLOC: write_alloc_reg <= cfg_data[0];
                sacam_pkg::REG_REPLACE:     replace_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // effective geometry
    logic [3:0]       off_eff;
    logic [4:0]       ib_eff;
    logic [WC_W-1:0]  nw;
    logic [CST_W-1:0] block_cost;

    always_comb begin
        if (offset_bits_reg < sacam_pkg::OFF_MIN) begin
            off_eff = sacam_pkg::OFF_MIN;
        end else if (offset_bits_reg > sacam_pkg::OFF_MAX) begin
            off_eff = sacam_pkg::OFF_MAX;
        end else begin
            off_eff = offset_bits_reg;
        end
        if (32'(index_bits_reg) > IB_MAX) begin
            ib_eff = 5'(IB_MAX);
        end else begin
            ib_eff = 5'(index_bits_reg);
        end
        if (ways_reg == 3'd0) begin
            nw = WC_W'(1);
        end else if (32'(ways_reg) > NUM_WAYS) begin
            nw = WC_W'(NUM_WAYS);
        end else begin
            nw = WC_W'(ways_reg);
        end
        block_cost = sacam_pkg::MEM_CYCLES << (off_eff - sacam_pkg::OFF_MIN);
    end

    // sequencer and access registers
    sacam_pkg::state_t state_reg, state_next;
    logic              is_store_reg;
    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [WC_W-1:0]   way_cnt_reg;
    logic              hit_reg, inv_found_reg;
    logic [WAY_W-1:0]  hit_way_reg, inv_way_reg, best_way_reg;
    logic [ST_W-1:0]   best_reg;
    logic [ST_W-1:0]   stamp_reg;
    logic [CNT_W-1:0]  cnt_reg [6];
    logic [ST_W-1:0]   cycle_total_reg;
    logic              out_valid_reg;
    logic              res_hit_reg, res_wb_reg, res_fill_reg;
    logic [CST_W-1:0]  res_cost_reg;

    logic [31:0]       addr_shift;
    logic [31:0]       set_mask;
    logic              accept;
    logic              out_free;
    logic              do_update;

    sacam_pkg::way_entry_t [NUM_WAYS-1:0] rd_row;
    sacam_pkg::way_entry_t [NUM_WAYS-1:0] wr_row;
    sacam_pkg::way_entry_t                cur;
    logic [ST_W-1:0]                      cur_stamp;
    logic [WAY_W-1:0]                     cur_way;
    logic [WAY_W-1:0]                     victim;
    logic                                 wrote_back;
    logic                                 filled;
    logic [CST_W-1:0]                     cost;

    assign s_tready  = (state_reg == sacam_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign do_update = (state_reg == sacam_pkg::ST_UPDATE) && out_free;

    assign addr_shift = s_tdata >> off_eff;
    assign set_mask   = 32'((33'd1 << ib_eff) - 33'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sacam_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sacam_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = sacam_pkg::ST_READ;
                end
            end
            sacam_pkg::ST_READ: state_next = sacam_pkg::ST_SCAN;
            sacam_pkg::ST_SCAN: begin
                if (way_cnt_reg == nw - WC_W'(1)) begin
                    state_next = sacam_pkg::ST_UPDATE;
                end
            end
            sacam_pkg::ST_UPDATE: begin
                if (out_free) begin
                    state_next = sacam_pkg::ST_IDLE;
                end
            end
            default: state_next = sacam_pkg::ST_IDLE;
        endcase
    end

    sacam_set_store #(
        .NUM_WAYS (NUM_WAYS),
        .ROWS     (ROWS),
        .SET_W    (SET_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (state_reg == sacam_pkg::ST_READ),
        .rd_addr (set_reg),
        .rd_row  (rd_row),
        .wr_en   (do_update),
        .wr_addr (set_reg),
        .wr_row  (wr_row)
    );

    // shared way comparator
    assign cur_way   = way_cnt_reg[WAY_W-1:0];
    assign cur       = rd_row[cur_way];
    assign cur_stamp = replace_reg ? cur.fill_stamp : cur.use_stamp;

    always_ff @(posedge aclk) begin
        if (accept) begin
            is_store_reg <= s_tuser[0];
            set_reg      <= SET_W'(addr_shift & set_mask);
            tag_reg      <= TAG_W'(s_tdata >> (6'(off_eff) + 6'(ib_eff)));
        end
        if (state_reg == sacam_pkg::ST_READ) begin
            way_cnt_reg   <= '0;
            hit_reg       <= 1'b0;
            inv_found_reg <= 1'b0;
        end
        if (state_reg == sacam_pkg::ST_SCAN) begin
            way_cnt_reg <= way_cnt_reg + WC_W'(1);
            if (!hit_reg && cur.valid && cur.tag == tag_reg) begin
                hit_reg     <= 1'b1;
                hit_way_reg <= cur_way;
            end
            if (!inv_found_reg && !cur.valid) begin
                inv_found_reg <= 1'b1;
                inv_way_reg   <= cur_way;
            end
            if (way_cnt_reg == '0 || cur_stamp < best_reg) begin
                best_reg     <= cur_stamp;
                best_way_reg <= cur_way;
            end
        end
    end

    // set update and cost
    always_comb begin
        victim     = inv_found_reg ? inv_way_reg : best_way_reg;
        wr_row     = rd_row;
        wrote_back = 1'b0;
        filled     = 1'b0;
        if (hit_reg) begin
            cost = CST_W'(1);
            wr_row[hit_way_reg].use_stamp = stamp_reg;
            if (is_store_reg) begin
                wr_row[hit_way_reg].dirty = write_back_reg;
            end
        end else if (is_store_reg && !write_alloc_reg) begin
            cost = CST_W'(1) + sacam_pkg::MEM_CYCLES;
        end else begin
            filled = 1'b1;
            wrote_back = write_back_reg && rd_row[victim].valid && rd_row[victim].dirty;
            cost = CST_W'(1) + block_cost + (wrote_back ? block_cost : CST_W'(0));
            wr_row[victim].tag        = tag_reg;
            wr_row[victim].valid      = 1'b1;
            wr_row[victim].dirty      = write_back_reg && is_store_reg;
            wr_row[victim].fill_stamp = stamp_reg;
            wr_row[victim].use_stamp  = stamp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stamp_reg       <= '0;
            cycle_total_reg <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (do_update) begin
                out_valid_reg   <= 1'b1;
                cycle_total_reg <= cycle_total_reg + ST_W'(cost);
                if (hit_reg || filled) begin
                    stamp_reg <= stamp_reg + ST_W'(1);
                end
                if (is_store_reg) begin
                    if (hit_reg) begin
                        cnt_reg[2] <= cnt_reg[2] + CNT_W'(1);
                    end else begin
                        cnt_reg[3] <= cnt_reg[3] + CNT_W'(1);
                    end
                    cnt_reg[5] <= cnt_reg[5] + CNT_W'(1);
                end else begin
                    if (hit_reg) begin
                        cnt_reg[0] <= cnt_reg[0] + CNT_W'(1);
                    end else begin
                        cnt_reg[1] <= cnt_reg[1] + CNT_W'(1);
                    end
                    cnt_reg[4] <= cnt_reg[4] + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_update) begin
            res_hit_reg  <= hit_reg;
            res_wb_reg   <= wrote_back;
            res_fill_reg <= filled;
            res_cost_reg <= cost;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, cycle_total_reg, cnt_reg[5], cnt_reg[4], cnt_reg[3],
                       cnt_reg[2], cnt_reg[1], cnt_reg[0], res_cost_reg,
                       res_fill_reg, res_wb_reg, res_hit_reg};

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == sacam_pkg::ST_READ)
        else $error("accepted access did not start a set read");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sacam_pkg::ST_SCAN |-> way_cnt_reg < nw)
        else $error("way scan ran past the ways in use");

    a_hit_no_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res_hit_reg && res_fill_reg) && (!res_wb_reg || res_fill_reg))
        else $error("inconsistent hit, fill and write-back flags");

    a_stamp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !do_update |=> stamp_reg == $past(stamp_reg))
        else $error("stamp counter moved outside an update");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(res_cost_reg))
        else $error("pending result overwritten");
`endif

endmodule

// ===== bench/sacam_checker.sv =====
// sacam_checker: predicts every result word of the cache access model and compares it
// depends on sacam_pkg; watches the input, result and configuration channels of the dut
`timescale 1ns / 1ps

module sacam_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [sacam_pkg::ADDR_W-1:0]        s_tdata,
    input  logic [0:0]                          s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [sacam_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [sacam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sacam_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                  error_count,
    output int                                  pending_count
);

    localparam int SETS   = sacam_pkg::MAX_SETS_DEF;
    localparam int WAYS   = sacam_pkg::NUM_WAYS_DEF;
    localparam int IB_MAX = $clog2(SETS + 1) - 1;

    typedef struct packed {
        logic        hit;
        logic        wrote_back;
        logic        filled;
        logic [15:0] cost;
        logic [31:0] ld_hit_cnt;
        logic [31:0] ld_miss_cnt;
        logic [31:0] st_hit_cnt;
        logic [31:0] st_miss_cnt;
        logic [31:0] loads;
        logic [31:0] stores;
        logic [63:0] cycles;
    } access_result_t;

    access_result_t expected_q[$];

    logic [29:0] tag_mem[SETS][WAYS];
    logic        valid_mem[SETS][WAYS];
    logic        dirty_mem[SETS][WAYS];
    logic [63:0] fill_mem[SETS][WAYS];
    logic [63:0] use_mem[SETS][WAYS];
    logic [63:0] stamp;
    logic [31:0] ld_hit_cnt, ld_miss_cnt, st_hit_cnt, st_miss_cnt, loads, stores;
    logic [63:0] cycles;
    logic [3:0]  cfg_off, cfg_idx;
    logic [2:0]  cfg_ways;
    logic        cfg_wb, cfg_wa, cfg_fifo;

    assign pending_count = expected_q.size();

    task automatic predict_access(input logic is_store, input logic [31:0] addr);
        int unsigned off, ib, nw, set, victim, w;
        logic [29:0] tag;
        logic [15:0] block_cost;
        logic [63:0] best, s;
        access_result_t r;
        off = cfg_off < 2 ? 2 : (cfg_off > 10 ? 10 : cfg_off);
        ib = cfg_idx > IB_MAX ? IB_MAX : cfg_idx;
        nw = cfg_ways == 0 ? 1 : (cfg_ways > WAYS ? WAYS : cfg_ways);
        block_cost = 16'((1 << (off - 2)) * 100);
        set = (addr >> off) & ((1 << ib) - 1);
        tag = 30'(addr >> (off + ib));
        r = '0;
        victim = nw;
        for (w = 0; w < nw; w++) begin
            if (r.hit == 1'b0 && valid_mem[set][w] && tag_mem[set][w] == tag) begin
                r.hit = 1'b1;
                victim = w;
            end
        end
        if (r.hit) begin
            use_mem[set][victim] = stamp;
            stamp = stamp + 1;
            if (is_store) dirty_mem[set][victim] = cfg_wb;
            r.cost = 16'd1;
        end else if (is_store && !cfg_wa) begin
            r.cost = 16'd101;
        end else begin
            for (w = nw; w > 0; w--)
                if (!valid_mem[set][w-1]) victim = w - 1;
            if (victim == nw) begin
                victim = 0;
                best = 0;
                for (w = 0; w < nw; w++) begin
                    s = cfg_fifo ? fill_mem[set][w] : use_mem[set][w];
                    if (w == 0 || s < best) begin
                        best = s;
                        victim = w;
                    end
                end
            end
            r.cost = 16'd1 + block_cost;
            if (cfg_wb && valid_mem[set][victim] && dirty_mem[set][victim]) begin
                r.wrote_back = 1'b1;
                r.cost = r.cost + block_cost;
            end
            r.filled = 1'b1;
            tag_mem[set][victim] = tag;
            valid_mem[set][victim] = 1'b1;
            dirty_mem[set][victim] = cfg_wb && is_store;
            fill_mem[set][victim] = stamp;
            use_mem[set][victim] = stamp;
            stamp = stamp + 1;
        end
        if (is_store) begin
            if (r.hit) st_hit_cnt++; else st_miss_cnt++;
            stores++;
        end else begin
            if (r.hit) ld_hit_cnt++; else ld_miss_cnt++;
            loads++;
        end
        cycles = cycles + r.cost;
        r.ld_hit_cnt = ld_hit_cnt;
        r.ld_miss_cnt = ld_miss_cnt;
        r.st_hit_cnt = st_hit_cnt;
        r.st_miss_cnt = st_miss_cnt;
        r.loads = loads;
        r.stores = stores;
        r.cycles = cycles;
        expected_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    task automatic compare_word(input logic [sacam_pkg::M_DATA_W-1:0] d);
        access_result_t e;
        e = expected_q.pop_front();
        check_field("hit", 64'(e.hit), 64'(d[0]));
        check_field("wrote_back", 64'(e.wrote_back), 64'(d[1]));
        check_field("filled", 64'(e.filled), 64'(d[2]));
        check_field("cycle_cost", 64'(e.cost), 64'(d[18:3]));
        check_field("load_hit_count", 64'(e.ld_hit_cnt), 64'(d[50:19]));
        check_field("load_miss_count", 64'(e.ld_miss_cnt), 64'(d[82:51]));
        check_field("store_hit_count", 64'(e.st_hit_cnt), 64'(d[114:83]));
        check_field("store_miss_count", 64'(e.st_miss_cnt), 64'(d[146:115]));
        check_field("load_total", 64'(e.loads), 64'(d[178:147]));
        check_field("store_total", 64'(e.stores), 64'(d[210:179]));
        check_field("cycle_total", e.cycles, d[274:211]);
    endtask

    initial begin
        for (int i = 0; i < SETS; i++)
            for (int j = 0; j < WAYS; j++) begin
                tag_mem[i][j] = '0;
                valid_mem[i][j] = 1'b0;
                dirty_mem[i][j] = 1'b0;
                fill_mem[i][j] = '0;
                use_mem[i][j] = '0;
            end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            error_count = 0;
            stamp = '0;
            {ld_hit_cnt, ld_miss_cnt, st_hit_cnt, st_miss_cnt, loads, stores} = '0;
            cycles = '0;
            cfg_off = 4'd4;
            cfg_idx = 4'd0;
            cfg_ways = 3'd1;
            cfg_wb = 1'b1;
            cfg_wa = 1'b1;
            cfg_fifo = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected");
                    error_count++;
                end else begin
                    compare_word(m_tdata);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sacam_pkg::REG_OFFSET_BITS: cfg_off = cfg_data[3:0];
                    sacam_pkg::REG_INDEX_BITS:  cfg_idx = cfg_data[3:0];
                    sacam_pkg::REG_WAYS:        cfg_ways = cfg_data[2:0];
                    sacam_pkg::REG_WRITE_BACK:  cfg_wb = cfg_data[0];
                    sacam_pkg::REG_WRITE_ALLOC: cfg_wa = cfg_data[0];
                    sacam_pkg::REG_REPLACE:     cfg_fifo = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_access(s_tuser[0], s_tdata);
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// tb_top: stimulus, stalls and verdict for the set-associative cache access model
// depends on sacam_pkg, set_assoc_cache_access_model and sacam_checker
`timescale 1ns / 1ps

module tb_top;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid, s_tready;
    logic [sacam_pkg::ADDR_W-1:0]     s_tdata;    // address
    logic [0:0]                       s_tuser;    // command
    logic                             m_tvalid, m_tready;
    // hit, wrote_back, filled, cycle_cost, counters, cycle_total
    logic [sacam_pkg::M_DATA_W-1:0]   m_tdata;
    logic                             cfg_valid, cfg_ready;
    logic [sacam_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sacam_pkg::CFG_DATA_W-1:0] cfg_data;
    int                               error_count, pending_count;
    logic                             hold_request;
    logic                             hold_done;
    int                               burst_left;
    int                               idle_cycles;

    set_assoc_cache_access_model dut (.*);

    sacam_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        m_tready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                case ($urandom_range(0, 3))
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'b1;
                    2: m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 5000) begin
                $display("[set_assoc_cache_access_model] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [sacam_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= sacam_pkg::CFG_DATA_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_access(input logic is_store, input logic [31:0] addr);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= is_store;
        s_tdata <= addr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_config(input int off, input int ib, input int nw,
                              input int wb, input int wa, input int rp);
        write_reg(sacam_pkg::REG_OFFSET_BITS, off);
        write_reg(sacam_pkg::REG_INDEX_BITS, ib);
        write_reg(sacam_pkg::REG_WAYS, nw);
        write_reg(sacam_pkg::REG_WRITE_BACK, wb);
        write_reg(sacam_pkg::REG_WRITE_ALLOC, wa);
        write_reg(sacam_pkg::REG_REPLACE, rp);
    endtask

    // well-formed traffic: a small pool of blocks crowding few sets, plus noise
    task automatic random_phase(input int off, input int ib, input int count,
                                input logic long_hold);
        logic [31:0] pool[12];
        logic [31:0] addr;
        int eo, eb;
        eo = off < 2 ? 2 : (off > 10 ? 10 : off);
        eb = ib > 8 ? 8 : ib;
        foreach (pool[i])
            pool[i] = ($urandom_range(0, 7) << (eo + eb)) |
                      (($urandom_range(0, 3) & ((1 << eb) - 1)) << eo);
        for (int n = 0; n < count; n++) begin
            if (long_hold && n == count / 2) hold_request <= 1'b1;
            if ($urandom_range(0, 99) < 85)
                addr = pool[$urandom_range(0, 11)] | ($urandom & ((1 << eo) - 1));
            else
                addr = $urandom;
            send_access($urandom_range(0, 1), addr);
        end
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_request = 1'b0;
        burst_left = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: direct mapped single block, write-back, allocate
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b0, 32'h0000_000C);
        send_access(1'b1, 32'h0000_0004);
        send_access(1'b0, 32'h0000_0010);
        send_access(1'b1, 32'hFFFF_FFFF);
        send_access(1'b1, 32'hFFFF_FFF0);
        send_access(1'b0, 32'h0000_0000);
        drain();
        // write-back without allocate, fifo, largest sizes
        set_config(10, 8, 4, 1, 0, 1);
        send_access(1'b1, 32'h0004_0000);
        send_access(1'b0, 32'h0004_0000);
        send_access(1'b1, 32'h0004_0000);
        send_access(1'b0, 32'h0008_0000);
        send_access(1'b0, 32'h000C_0000);
        send_access(1'b0, 32'h0010_0000);
        send_access(1'b0, 32'h0014_0000);
        send_access(1'b0, 32'hFFFF_FFFF);
        drain();
        // out-of-range register values clamp
        set_config(0, 15, 0, 0, 0, 0);
        send_access(1'b1, 32'h8000_0000);
        send_access(1'b0, 32'h8000_0000);
        send_access(1'b1, 32'h8000_0000);
        send_access(1'b0, 32'h7FFF_FFFC);
        drain();
        set_config(15, 0, 7, 1, 1, 1);
        send_access(1'b1, 32'h0000_0400);
        send_access(1'b0, 32'h0000_0000);
        drain();

        random_phase(15, 0, 60, 1'b0);
        set_config(4, 2, 4, 1, 1, 0);
        random_phase(4, 2, 90, 1'b1);
        set_config(2, 0, 4, 1, 1, 1);
        random_phase(2, 0, 80, 1'b0);
        set_config(6, 8, 3, 0, 1, 0);
        random_phase(6, 8, 70, 1'b0);
        set_config(10, 1, 2, 1, 0, 1);
        random_phase(10, 1, 70, 1'b0);
        set_config(3, 3, 4, 0, 0, 0);
        random_phase(3, 3, 70, 1'b0);
        set_config(5, 1, 4, 1, 1, 0);
        random_phase(5, 1, 80, 1'b0);
        set_config(2, 0, 1, 1, 1, 1);
        random_phase(2, 0, 60, 1'b0);

        if (error_count == 0)
            $display("[set_assoc_cache_access_model] OK");
        else
            $display("[set_assoc_cache_access_model] ERROR");
        $finish;
    end

endmodule
